/* rtl/led_strip_effect_generator_unit_defines.svh */
// assertion macros for the led strip effect generator
`ifndef LED_STRIP_EFFECT_GENERATOR_UNIT_DEFINES_SVH
`define LED_STRIP_EFFECT_GENERATOR_UNIT_DEFINES_SVH

// condition must hold on every clock edge out of reset
`define LSEG_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the trigger
`define LSEG_ASSERT_IMPL(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the trigger
`define LSEG_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

/* rtl/lseg_pkg.sv */
package lseg_pkg;

  localparam int PIXEL_COUNT = 60;
  localparam int STORE_DEPTH = 64;
  localparam int IDX_W       = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int HOLD_W      = 6;
  localparam int RGB_W       = 24;

  localparam logic [IDX_W-1:0] LAST_PIX = IDX_W'(PIXEL_COUNT - 1);

  localparam logic [HOLD_W-1:0] HOLD_RAINBOW = 6'd20;
  localparam logic [HOLD_W-1:0] HOLD_CHASE   = 6'd50;
  localparam logic [HOLD_W-1:0] HOLD_OTHER   = 6'd10;

  localparam logic [8:0] WHEEL_WRAP = 9'd255;

  typedef enum logic [2:0] {
    MODE_RAINBOW       = 3'd0,
    MODE_CHASE         = 3'd1,
    MODE_CHASE_RAINBOW = 3'd2,
    MODE_SOLID         = 3'd3,
    MODE_WIPE          = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_ENABLE = 3'd1,
    CFG_RED    = 3'd2,
    CFG_GREEN  = 3'd3,
    CFG_BLUE   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FINISH
  } state_t;

  // three-segment color wheel, red in the top byte
  function automatic logic [RGB_W-1:0] lseg_wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] seg;
    logic [9:0] tri3;
    logic [7:0] up;
    logic [7:0] down;
    p = ~pos;
    if (p < 8'd85) begin
      seg = p;
    end else if (p < 8'd170) begin
      seg = p - 8'd85;
    end else begin
      seg = p - 8'd170;
    end
    tri3 = {2'b00, seg} + {1'b0, seg, 1'b0};
    up   = tri3[7:0];
    down = 8'd255 - tri3[7:0];
    if (p < 8'd85) begin
      lseg_wheel = {down, 8'd0, up};
    end else if (p < 8'd170) begin
      lseg_wheel = {8'd0, up, down};
    end else begin
      lseg_wheel = {up, down, 8'd0};
    end
  endfunction

endpackage

/* rtl/led_strip_effect_generator_unit.sv */
// first pixel: an accepted frame tick moves the sequencer to fetch; the pixel is read
//   from the store into the read stage, then loaded into the output register
// throughput: one pixel per cycle unless m_tready stalls the output register
// a tick with an undefined mode while enabled is accepted and emits nothing
// reset: synchronous, active high; clears state, config and counter registers and the
//   store valid bits, so every pixel reads as off
`include "led_strip_effect_generator_unit_defines.svh"

module led_strip_effect_generator_unit
  import lseg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] restart
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // pixel_index, out_red, out_green, out_blue, hold_ms
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [2:0] effect_mode;
  logic       strip_enabled;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;

  state_t state;
  state_t state_next;

  logic [7:0]       frame_step;
  logic [1:0]       chase_phase;
  logic [IDX_W-1:0] wipe_pos;

  logic [IDX_W-1:0] rd_idx;
  logic [1:0]       rd_c3;

  logic [RGB_W-1:0] pix_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] pix_ok;
  logic [RGB_W-1:0] rdata;
  logic             rd_ok;
  logic             b_valid;
  logic [IDX_W-1:0] b_idx;
  logic [1:0]       b_c3;

  logic             o_valid;
  logic [IDX_W-1:0] o_idx;
  logic [RGB_W-1:0] o_rgb;
  logic [HOLD_W-1:0] o_hold;
  logic             o_last;

  logic restart;
  logic tick_acc;
  logic mode_known;
  logic fetch_en;
  logic advance_out;
  logic load;
  logic issue;
  logic b_last;
  logic member;
  logic is_chase_rb;
  logic [1:0]       sub_q;
  logic [8:0]       pos_sum;
  logic [7:0]       wheel_pos;
  logic [RGB_W-1:0] wheel_rgb;
  logic [RGB_W-1:0] old_pix;
  logic [RGB_W-1:0] fixed_rgb;
  logic [RGB_W-1:0] show_pix;
  logic [RGB_W-1:0] keep_pix;
  logic [HOLD_W-1:0] hold_val;
  logic [IDX_W:0]   wipe_inc;

  assign restart    = s_tdata[0];
  assign cfg_ready  = 1'b1;
  assign tick_acc   = s_tvalid && s_tready;
  assign mode_known = (effect_mode <= MODE_WIPE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode   <= MODE_RAINBOW;
      strip_enabled <= 1'b0;
      red_level     <= 8'd0;
      green_level   <= 8'd0;
      blue_level    <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:   effect_mode   <= cfg_data[2:0];
        CFG_ENABLE: strip_enabled <= cfg_data[0];
        CFG_RED:    red_level     <= cfg_data;
        CFG_GREEN:  green_level   <= cfg_data;
        CFG_BLUE:   blue_level    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick_acc && (!strip_enabled || mode_known)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (issue && (rd_idx == LAST_PIX)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load && b_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    fetch_en = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready = 1'b1;
      ST_FETCH:  fetch_en = 1'b1;
      ST_FINISH: ;
      default: ;
    endcase
  end

  assign advance_out = !o_valid || m_tready;
  assign load        = b_valid && advance_out;
  assign issue       = fetch_en && (!b_valid || load);
  assign b_last      = (b_idx == LAST_PIX);

  // read address walk
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      rd_c3  <= 2'd0;
    end else if (tick_acc) begin
      rd_idx <= '0;
      rd_c3  <= 2'd0;
    end else if (issue) begin
      rd_idx <= rd_idx + IDX_W'(1);
      rd_c3  <= (rd_c3 == 2'd2) ? 2'd0 : rd_c3 + 2'd1;
    end
  end

  // pixel store
  always_ff @(posedge clk) begin
    if (load) begin
      pix_mem[b_idx] <= keep_pix;
    end
    if (issue) begin
      rdata <= pix_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_ok <= '0;
    end else if (load) begin
      pix_ok[b_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_ok <= pix_ok[rd_idx];
      b_idx <= rd_idx;
      b_c3  <= rd_c3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (issue) begin
      b_valid <= 1'b1;
    end else if (load) begin
      b_valid <= 1'b0;
    end
  end

  // shared color unit
  assign old_pix     = rd_ok ? rdata : '0;
  assign fixed_rgb   = {red_level, green_level, blue_level};
  assign member      = (b_c3 == chase_phase);
  assign is_chase_rb = (effect_mode == MODE_CHASE_RAINBOW);
  assign sub_q       = is_chase_rb ? chase_phase : 2'd0;
  assign pos_sum     = {3'b000, b_idx - {4'b0000, sub_q}} + {1'b0, frame_step};
  assign wheel_pos   = (is_chase_rb && (pos_sum >= WHEEL_WRAP)) ? 8'(pos_sum - WHEEL_WRAP)
                                                               : pos_sum[7:0];
  assign wheel_rgb   = lseg_wheel(wheel_pos);

  always_comb begin
    show_pix = old_pix;
    keep_pix = old_pix;
    hold_val = HOLD_OTHER;
    if (!strip_enabled) begin
      show_pix = '0;
      keep_pix = '0;
    end else begin
      case (effect_mode)
        MODE_RAINBOW: begin
          show_pix = wheel_rgb;
          keep_pix = wheel_rgb;
          hold_val = HOLD_RAINBOW;
        end
        MODE_CHASE: begin
          hold_val = HOLD_CHASE;
          if (member) begin
            show_pix = fixed_rgb;
            keep_pix = '0;
          end
        end
        MODE_CHASE_RAINBOW: begin
          hold_val = HOLD_CHASE;
          if (member) begin
            show_pix = wheel_rgb;
            keep_pix = '0;
          end
        end
        MODE_SOLID: begin
          show_pix = fixed_rgb;
          keep_pix = fixed_rgb;
        end
        MODE_WIPE: begin
          hold_val = HOLD_CHASE;
          if (b_idx == wipe_pos) begin
            show_pix = fixed_rgb;
            keep_pix = fixed_rgb;
          end
        end
        default: ;
      endcase
    end
  end

  // effect counters
  assign wipe_inc = {1'b0, wipe_pos} + (IDX_W+1)'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_step  <= 8'd0;
      chase_phase <= 2'd0;
      wipe_pos    <= '0;
    end else if (tick_acc && (restart || !strip_enabled)) begin
      frame_step  <= 8'd0;
      chase_phase <= 2'd0;
      wipe_pos    <= '0;
    end else if (load && b_last && strip_enabled) begin
      case (effect_mode)
        MODE_RAINBOW: frame_step <= frame_step + 8'd1;
        MODE_CHASE: begin
          chase_phase <= (chase_phase >= 2'd2) ? 2'd0 : chase_phase + 2'd1;
        end
        MODE_CHASE_RAINBOW: begin
          if (chase_phase >= 2'd2) begin
            chase_phase <= 2'd0;
            frame_step  <= frame_step + 8'd1;
          end else begin
            chase_phase <= chase_phase + 2'd1;
          end
        end
        MODE_WIPE: begin
          wipe_pos <= (wipe_inc >= (IDX_W+1)'(PIXEL_COUNT)) ? '0 : wipe_inc[IDX_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_idx  <= b_idx;
      o_rgb  <= show_pix;
      o_hold <= hold_val;
      o_last <= b_last;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tlast  = o_last;
  assign m_tdata  = {4'b0000, o_hold, o_rgb[7:0], o_rgb[15:8], o_rgb[23:16], o_idx};

  `LSEG_ASSERT_NEXT(a_last_pixel_ends_tick, load && b_last, state == ST_IDLE,
                    "tick did not end after last pixel")
  `LSEG_ASSERT_IMPL(a_stage_only_in_tick, b_valid, state != ST_IDLE,
                    "pixel in flight while idle")
  `LSEG_ASSERT_ALWAYS(a_phase_range, chase_phase != 2'd3, "chase phase out of range")
  `LSEG_ASSERT_ALWAYS(a_wipe_range, {1'b0, wipe_pos} < (IDX_W+1)'(PIXEL_COUNT),
                      "wipe position past strip")
  `LSEG_ASSERT_NEXT(a_restart_clears, tick_acc && restart,
                    (frame_step == 8'd0) && (chase_phase == 2'd0) && (wipe_pos == '0),
                    "restart did not clear counters")

endmodule
